// ===== hw/rtl/ra6r5_pkg.sv =====
package ra6r5_pkg;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    // register stages in the polynomial and field sections
    localparam int POLY_STAGES  = 6;
    localparam int FIELD_STAGES = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EASY_X = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EASY_Y = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EASY_Z = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REF_X  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REF_Y  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_REF_Z  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ANISO  = 4'd7;

    localparam logic signed [15:0] AXIS_ONE = 16'sd32767;

    // 1.0 in Q.24
    localparam logic signed [32:0] ONE_Q24 = 33'sd16777216;

    typedef struct packed {
        logic signed [15:0] spin_x;
        logic signed [15:0] spin_y;
        logic signed [15:0] spin_z;
        logic signed [31:0] field_in_x;
        logic signed [31:0] field_in_y;
        logic signed [31:0] field_in_z;
        logic               last_in;
    } in_t;

    typedef struct packed {
        logic signed [31:0] field_x;
        logic signed [31:0] field_y;
        logic signed [31:0] field_z;
        logic signed [31:0] energy;
        logic               last_out;
    } out_t;

    typedef struct packed {
        logic               enable;
        logic signed [15:0] easy_x;
        logic signed [15:0] easy_y;
        logic signed [15:0] easy_z;
        logic signed [15:0] ref_x;
        logic signed [15:0] ref_y;
        logic signed [15:0] ref_z;
        logic signed [31:0] k;
        logic signed [34:0] k5;    // 5 * k, feeds the x-axis term
    } cfg_t;

    // register defaults: disabled, easy axis +z, reference axis +x, k = 0
    localparam cfg_t CFG_RESET = '{
        enable: 1'b0,
        easy_x: 16'sd0,
        easy_y: 16'sd0,
        easy_z: AXIS_ONE,
        ref_x:  AXIS_ONE,
        ref_y:  16'sd0,
        ref_z:  16'sd0,
        k:      32'sd0,
        k5:     35'sd0
    };

    // fields that ride along the pipe untouched
    typedef struct packed {
        logic signed [31:0] fin_x;
        logic signed [31:0] fin_y;
        logic signed [31:0] fin_z;
        logic               last;
    } side_t;

    // polynomial times projection, Q.24
    typedef struct packed {
        logic signed [31:0] ae;
        logic signed [31:0] axr;
        logic signed [31:0] az;
        side_t              side;
    } mid_t;

    // Q.30 dot product -> Q.24, clamped to +-1.0
    function automatic logic signed [25:0] proj_round(input logic signed [33:0] d);
        logic signed [33:0] t;
        t = (d + 34'sd32) >>> 6;
        if (t > 34'sd16777216) begin
            proj_round = 26'sd16777216;
        end else if (t < -34'sd16777216) begin
            proj_round = -26'sd16777216;
        end else begin
            proj_round = t[25:0];
        end
    endfunction

    function automatic logic signed [25:0] rnd24_52(input logic signed [51:0] p);
        logic signed [51:0] t;
        t = (p + 52'sd8388608) >>> 24;
        rnd24_52 = t[25:0];
    endfunction

    function automatic logic signed [31:0] rnd24_59(input logic signed [58:0] p);
        logic signed [58:0] t;
        t = (p + 59'sd8388608) >>> 24;
        rnd24_59 = t[31:0];
    endfunction

    function automatic logic signed [41:0] rnd24_67(input logic signed [66:0] p);
        logic signed [66:0] t;
        t = (p + 67'sd8388608) >>> 24;
        rnd24_67 = t[41:0];
    endfunction

    function automatic logic signed [43:0] rnd15_59(input logic signed [58:0] p);
        logic signed [58:0] t;
        t = (p + 59'sd16384) >>> 15;
        rnd15_59 = t[43:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [45:0] x);
        if (x > 46'sd2147483647) begin
            sat32 = 32'sh7fffffff;
        end else if (x < -46'sd2147483648) begin
            sat32 = 32'sh80000000;
        end else begin
            sat32 = x[31:0];
        end
    endfunction

endpackage

// ===== hw/rtl/ra6r5_cfg.sv =====
module ra6r5_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ra6r5_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ra6r5_pkg::CFG_DATA_W-1:0] cfg_data,
    output ra6r5_pkg::cfg_t                  cfg
);
    import ra6r5_pkg::*;

    cfg_t cfg_reg, cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_ENABLE: cfg_next.enable = cfg_data[0];
                REG_EASY_X: cfg_next.easy_x = cfg_data[15:0];
                REG_EASY_Y: cfg_next.easy_y = cfg_data[15:0];
                REG_EASY_Z: cfg_next.easy_z = cfg_data[15:0];
                REG_REF_X:  cfg_next.ref_x  = cfg_data[15:0];
                REG_REF_Y:  cfg_next.ref_y  = cfg_data[15:0];
                REG_REF_Z:  cfg_next.ref_z  = cfg_data[15:0];
                REG_ANISO: begin
                    cfg_next.k  = cfg_data;
                    cfg_next.k5 = (35'($signed(cfg_data)) <<< 2) + 35'($signed(cfg_data));
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== hw/rtl/ra6r5_poly.sv =====
module ra6r5_poly (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            adv,
    input  logic            in_valid,
    input  ra6r5_pkg::in_t  in_data,
    input  ra6r5_pkg::cfg_t cfg,
    output logic            out_valid,
    output ra6r5_pkg::mid_t out_data
);
    import ra6r5_pkg::*;

    logic [POLY_STAGES-1:0] vld_reg;
    side_t                  side_reg [POLY_STAGES];

    // A: axis products
    logic signed [31:0] pe_reg [3], pe_next [3];
    logic signed [31:0] pr_reg [3], pr_next [3];
    // B: projections
    logic signed [25:0] b_sz_reg, b_sz_next, b_sx_reg, b_sx_next;
    // C: squares
    logic signed [25:0] c_sz_reg, c_sx_reg;
    logic signed [25:0] c_sz2_reg, c_sz2_next, c_sx2_reg, c_sx2_next;
    logic signed [25:0] c_sxsz_reg, c_sxsz_next;
    // D: fourth-order terms
    logic signed [25:0] d_sz_reg, d_sx_reg, d_sz2_reg, d_sx2_reg, d_sxsz_reg;
    logic signed [25:0] d_sz4_reg, d_sz4_next, d_sx4_reg, d_sx4_next;
    logic signed [25:0] d_x2z2_reg, d_x2z2_next;
    // E: polynomials
    logic signed [25:0] e_sz_reg, e_sx_reg, e_sxsz_reg;
    logic signed [32:0] e_pe_reg, e_pe_next, e_px_reg, e_px_next, e_pz_reg, e_pz_next;
    // F: polynomial times projection
    logic signed [31:0] f_ae_reg, f_ae_next, f_axr_reg, f_axr_next, f_az_reg, f_az_next;

    logic signed [32:0] x4, z4, x2z2, x2, z2;

    always_comb begin
        pe_next[0] = 32'(in_data.spin_x) * 32'(cfg.easy_x);
        pe_next[1] = 32'(in_data.spin_y) * 32'(cfg.easy_y);
        pe_next[2] = 32'(in_data.spin_z) * 32'(cfg.easy_z);
        pr_next[0] = 32'(in_data.spin_x) * 32'(cfg.ref_x);
        pr_next[1] = 32'(in_data.spin_y) * 32'(cfg.ref_y);
        pr_next[2] = 32'(in_data.spin_z) * 32'(cfg.ref_z);

        b_sz_next = proj_round(34'(pe_reg[0]) + 34'(pe_reg[1]) + 34'(pe_reg[2]));
        b_sx_next = proj_round(34'(pr_reg[0]) + 34'(pr_reg[1]) + 34'(pr_reg[2]));

        c_sz2_next  = rnd24_52(52'(b_sz_reg) * 52'(b_sz_reg));
        c_sx2_next  = rnd24_52(52'(b_sx_reg) * 52'(b_sx_reg));
        c_sxsz_next = rnd24_52(52'(b_sx_reg) * 52'(b_sz_reg));

        d_sz4_next  = rnd24_52(52'(c_sz2_reg) * 52'(c_sz2_reg));
        d_sx4_next  = rnd24_52(52'(c_sx2_reg) * 52'(c_sx2_reg));
        d_x2z2_next = rnd24_52(52'(c_sx2_reg) * 52'(c_sz2_reg));

        x4   = 33'(d_sx4_reg);
        z4   = 33'(d_sz4_reg);
        x2z2 = 33'(d_x2z2_reg);
        x2   = 33'(d_sx2_reg);
        z2   = 33'(d_sz2_reg);
        e_pe_next = (x4 <<< 4) + x2z2 * 33'sd20 + z4 * 33'sd5
                  - x2 * 33'sd20 - z2 * 33'sd10 + ONE_Q24 * 33'sd5;
        e_px_next = (x4 <<< 4) + x2z2 * 33'sd12 + z4
                  - x2 * 33'sd12 - (z2 <<< 1) + ONE_Q24;
        e_pz_next = (x4 <<< 4) + x2z2 * 33'sd60 + z4 * 33'sd25
                  - x2 * 33'sd20 - z2 * 33'sd30 + ONE_Q24 * 33'sd5;

        f_ae_next  = rnd24_59(59'(e_pe_reg) * 59'(e_sxsz_reg));
        f_axr_next = rnd24_59(59'(e_px_reg) * 59'(e_sz_reg));
        f_az_next  = rnd24_59(59'(e_pz_reg) * 59'(e_sx_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[POLY_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_reg[0] <= '{fin_x: in_data.field_in_x, fin_y: in_data.field_in_y,
                             fin_z: in_data.field_in_z, last: in_data.last_in};
            for (int i = 1; i < POLY_STAGES; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
            pe_reg     <= pe_next;
            pr_reg     <= pr_next;
            b_sz_reg   <= b_sz_next;
            b_sx_reg   <= b_sx_next;
            c_sz_reg   <= b_sz_reg;
            c_sx_reg   <= b_sx_reg;
            c_sz2_reg  <= c_sz2_next;
            c_sx2_reg  <= c_sx2_next;
            c_sxsz_reg <= c_sxsz_next;
            d_sz_reg   <= c_sz_reg;
            d_sx_reg   <= c_sx_reg;
            d_sz2_reg  <= c_sz2_reg;
            d_sx2_reg  <= c_sx2_reg;
            d_sxsz_reg <= c_sxsz_reg;
            d_sz4_reg  <= d_sz4_next;
            d_sx4_reg  <= d_sx4_next;
            d_x2z2_reg <= d_x2z2_next;
            e_sz_reg   <= d_sz_reg;
            e_sx_reg   <= d_sx_reg;
            e_sxsz_reg <= d_sxsz_reg;
            e_pe_reg   <= e_pe_next;
            e_px_reg   <= e_px_next;
            e_pz_reg   <= e_pz_next;
            f_ae_reg   <= f_ae_next;
            f_axr_reg  <= f_axr_next;
            f_az_reg   <= f_az_next;
        end
    end

    assign out_valid     = vld_reg[POLY_STAGES-1];
    assign out_data.ae   = f_ae_reg;
    assign out_data.axr  = f_axr_reg;
    assign out_data.az   = f_az_reg;
    assign out_data.side = side_reg[POLY_STAGES-1];

endmodule

// ===== hw/rtl/ra6r5_field.sv =====
module ra6r5_field (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            adv,
    input  logic            in_valid,
    input  ra6r5_pkg::mid_t in_data,
    input  ra6r5_pkg::cfg_t cfg,
    output logic            out_valid,
    output ra6r5_pkg::out_t out_data
);
    import ra6r5_pkg::*;

    logic [FIELD_STAGES-1:0] vld_reg;
    side_t                   side_reg [FIELD_STAGES];

    // G: scale by k, Q.16
    logic signed [41:0] g_hx_reg, g_hx_next, g_hz_reg, g_hz_next, g_er_reg, g_er_next;
    // H: spread onto the two axes
    logic signed [57:0] h_pe_reg [3], h_pe_next [3];
    logic signed [57:0] h_pr_reg [3], h_pr_next [3];
    logic signed [31:0] h_en_reg, h_en_next;
    // I: rounded field increment
    logic signed [43:0] i_add_reg [3], i_add_next [3];
    logic signed [31:0] i_en_reg;

    logic signed [31:0] fin [3];

    always_comb begin
        g_hx_next = rnd24_67(67'(cfg.k5) * 67'(in_data.axr));
        g_hz_next = rnd24_67(67'(cfg.k) * 67'(in_data.az));
        g_er_next = rnd24_67(67'(cfg.k) * 67'(in_data.ae));

        h_pe_next[0] = 58'(g_hz_reg) * 58'(cfg.easy_x);
        h_pe_next[1] = 58'(g_hz_reg) * 58'(cfg.easy_y);
        h_pe_next[2] = 58'(g_hz_reg) * 58'(cfg.easy_z);
        h_pr_next[0] = 58'(g_hx_reg) * 58'(cfg.ref_x);
        h_pr_next[1] = 58'(g_hx_reg) * 58'(cfg.ref_y);
        h_pr_next[2] = 58'(g_hx_reg) * 58'(cfg.ref_z);
        h_en_next    = sat32(-46'(g_er_reg));

        for (int i = 0; i < 3; i++) begin
            i_add_next[i] = rnd15_59(59'(h_pe_reg[i]) + 59'(h_pr_reg[i]));
        end

        fin[0] = side_reg[FIELD_STAGES-1].fin_x;
        fin[1] = side_reg[FIELD_STAGES-1].fin_y;
        fin[2] = side_reg[FIELD_STAGES-1].fin_z;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[FIELD_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_reg[0] <= in_data.side;
            for (int i = 1; i < FIELD_STAGES; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
            g_hx_reg  <= g_hx_next;
            g_hz_reg  <= g_hz_next;
            g_er_reg  <= g_er_next;
            h_pe_reg  <= h_pe_next;
            h_pr_reg  <= h_pr_next;
            h_en_reg  <= h_en_next;
            i_add_reg <= i_add_next;
            i_en_reg  <= h_en_reg;
        end
    end

    // disabled: field passes through bit-exact
    assign out_valid        = vld_reg[FIELD_STAGES-1];
    assign out_data.field_x = cfg.enable ? sat32(46'(fin[0]) + 46'(i_add_reg[0])) : fin[0];
    assign out_data.field_y = cfg.enable ? sat32(46'(fin[1]) + 46'(i_add_reg[1])) : fin[1];
    assign out_data.field_z = cfg.enable ? sat32(46'(fin[2]) + 46'(i_add_reg[2])) : fin[2];
    assign out_data.energy  = i_en_reg;
    assign out_data.last_out = side_reg[FIELD_STAGES-1].last;

endmodule

// ===== hw/rtl/ra6r5_obuf.sv =====
module ra6r5_obuf (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    input  ra6r5_pkg::out_t in_data,
    output logic            adv,
    output logic            m_valid,
    input  logic            m_ready,
    output ra6r5_pkg::out_t m_data
);
    import ra6r5_pkg::*;

    logic out_valid_reg, out_valid_next;
    logic skid_valid_reg, skid_valid_next;
    out_t out_data_reg, out_data_next;
    out_t skid_data_reg, skid_data_next;
    logic take, load;

    // pipe moves only while the skid entry is free
    assign adv     = !skid_valid_reg;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;
    assign take    = out_valid_reg && m_ready;
    assign load    = in_valid && !skid_valid_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (take) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (load) begin
            if (!out_valid_reg || take) begin
                out_data_next  = in_data;
                out_valid_next = 1'b1;
            end else begin
                skid_data_next  = in_data;
                skid_valid_next = 1'b1;
            end
        end else if (take) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

// ===== hw/rtl/rotational_anisotropy_6r5_field.sv =====
// Channel  Dir  Handshake            Payload
// s_       in   s_valid / s_ready    in_t: spin, accumulated field, last_in
// m_       out  m_valid / m_ready    out_t: field, energy, last_out
// cfg_     in   cfg_valid/cfg_ready  cfg_index, cfg_data (register write)
//
// One item per cycle while s_ready is high. Six stages for projection, powers,
// polynomials and their products, three for scaling by k, axis spread and
// rounding, then the output register.
// Reset (aresetn low, synchronous) empties the pipe and loads register defaults.
// An output register plus one skid entry: on a stall the pipe freezes once the
// skid entry fills, and s_ready falls together with that freeze.
module rotational_anisotropy_6r5_field (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  ra6r5_pkg::in_t                   s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output ra6r5_pkg::out_t                  m_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ra6r5_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ra6r5_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ra6r5_pkg::*;

    cfg_t cfg;
    logic adv;
    logic mid_valid, res_valid;
    mid_t mid_data;
    out_t res_data;

    assign s_ready = adv;

    ra6r5_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ra6r5_poly u_poly (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_valid),
        .in_data   (s_data),
        .cfg       (cfg),
        .out_valid (mid_valid),
        .out_data  (mid_data)
    );

    ra6r5_field u_field (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (mid_valid),
        .in_data   (mid_data),
        .cfg       (cfg),
        .out_valid (res_valid),
        .out_data  (res_data)
    );

    ra6r5_obuf u_obuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (res_valid),
        .in_data  (res_data),
        .adv      (adv),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

// ===== hw/rtl/ra6r5_chk.sv =====
module ra6r5_chk (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input ra6r5_pkg::in_t                   s_data,
    input logic                             m_valid,
    input logic                             m_ready,
    input ra6r5_pkg::out_t                  m_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // a waiting input transfer holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("input changed while waiting");

    // nothing shown right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // input back-pressure only when the output register is full
    a_bp_out_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("s_ready low with empty output");

    // a full skid entry stays full until the output drains
    a_bp_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready && !m_ready |=> !s_ready)
        else $error("back-pressure released without a transfer");

endmodule

bind rotational_anisotropy_6r5_field ra6r5_chk u_chk (.*);
